>>> design/psr_pkg.sv
// Shared constants, types and cosine helpers for the stencil residual core.
package psr_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int ADDR_W         = $clog2(MAX_WIDTH);
    localparam int COS_TABLE_BITS = 8;
    localparam int COS_N          = 1 << COS_TABLE_BITS;
    localparam int COS_IDX_W      = COS_TABLE_BITS + 1;
    localparam int MAX_HEIGHT     = 4096;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    // Configuration register indexes.
    localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] REG_STEP_X      = 3'd2;
    localparam logic [2:0] REG_STEP_Y      = 3'd3;
    localparam logic [2:0] REG_RATIO_YX    = 3'd4;
    localparam logic [2:0] REG_RATIO_XY    = 3'd5;
    localparam logic [2:0] REG_FORCING     = 3'd6;

    // Multiplier operand selects.
    localparam logic [2:0] MUL_XL = 3'd0;
    localparam logic [2:0] MUL_XH = 3'd1;
    localparam logic [2:0] MUL_YL = 3'd2;
    localparam logic [2:0] MUL_YH = 3'd3;
    localparam logic [2:0] MUL_CC = 3'd4;
    localparam logic [2:0] MUL_F  = 3'd5;

    // Accumulator operations.
    localparam logic [1:0] ACC_NONE = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_HI   = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    typedef logic [COS_N:0][24:0] cos_rom_t;

    typedef struct packed {
        logic       capture;
        logic       rd_ctr;
        logic       rd_east;
        logic       prep;
        logic [2:0] mul_op;
        logic [1:0] acc_op;
        logic       load_prev_res;
        logic       load_row_res;
    } psr_cmd_t;

    typedef struct packed {
        logic out_free;
        logic has_prev;
        logic last_row;
    } psr_status_t;

    // Quarter-wave table: Taylor series in Q2.30, clamped to [0,1], rounded to Q24.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t           rom;
        logic [63:0]        theta;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rounded;
        rom = '0;
        for (int k = 0; k <= COS_N; k++) begin
            theta = (HALF_PI_Q30 * 64'(k)) >> COS_TABLE_BITS;
            x2    = (theta * theta) >> 30;
            term  = ONE_Q30;
            sum   = $signed(ONE_Q30);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > $signed(ONE_Q30)) begin
                sum = $signed(ONE_Q30);
            end
            rounded = ($unsigned(sum) + 64'd32) >> 6;
            rom[k]  = rounded[24:0];
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

    // Cosine of a 16-bit phase (turns/65536), signed Q24.
    function automatic logic signed [25:0] cos_q24(input logic [15:0] phase);
        logic [1:0]           quad;
        logic [COS_IDX_W-1:0] idx;
        logic [COS_IDX_W-1:0] ridx;
        logic signed [25:0]   direct;
        logic signed [25:0]   mirror;
        quad   = phase[15:14];
        idx    = {1'b0, phase[13 -: COS_TABLE_BITS]};
        ridx   = COS_IDX_W'(COS_N) - idx;
        direct = $signed({1'b0, COS_ROM[idx]});
        mirror = $signed({1'b0, COS_ROM[ridx]});
        case (quad)
            2'd0:    cos_q24 = direct;
            2'd1:    cos_q24 = -mirror;
            2'd2:    cos_q24 = -direct;
            default: cos_q24 = mirror;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sd2147483647) begin
            sat32 = 32'sh7FFFFFFF;
        end else if (v < -48'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

>>> design/poisson_stencil_residual_core.sv
// Top level of the five-point Laplacian residual core with its register file.
//
// The core takes grid values (signed Q8.24) in raster order, one per input beat,
// and returns residuals of the five-point Laplacian with a cosine forcing term.
// When cell (row, col) arrives, the residual of cell (row-1, col) is produced;
// on the last row the cell's own residual follows it, so one input beat gives
// zero, one or two output beats, and the very last one carries tlast. Each input
// beat, after its capture, passes through two read steps that fetch the center and
// east values from the single-port line store, a prep step that forms the
// differences and looks up the cosines, and seven multiply steps on the shared
// 27x33 multiplier that build both weighted differences in two halves each and
// then the cosine and forcing products, plus one output step per output beat it
// makes. s_tready is high only between items. A finished result waits in the
// output register, so a stalled output side delays the core only when a new
// result is ready while the output register still holds an untaken beat. The
// registers must be written over the APB port only while no item is in progress;
// the core does not enforce this. The line stores need no clearing after reset.
module poisson_stencil_residual_core
    import psr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] grid_value
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // [31:0] residual, [43:32] cell_row, [53:44] cell_col
    output logic        m_tlast   // grid_done
);

    logic [10:0] grid_width_reg;
    logic [12:0] grid_height_reg;
    logic [15:0] step_x_reg;
    logic [15:0] step_y_reg;
    logic [31:0] ratio_yx_reg;
    logic [31:0] ratio_xy_reg;
    logic [31:0] forcing_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    psr_cmd_t    cmd;
    psr_status_t status;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    // Register file; writes land in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 11'd3;
            grid_height_reg <= 13'd3;
            step_x_reg      <= 16'd32768;
            step_y_reg      <= 16'd32768;
            ratio_yx_reg    <= 32'd16777216;
            ratio_xy_reg    <= 32'd16777216;
            forcing_reg     <= 32'd331168970;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_GRID_WIDTH:  grid_width_reg  <= pwdata[10:0];
                REG_GRID_HEIGHT: grid_height_reg <= pwdata[12:0];
                REG_STEP_X:      step_x_reg      <= pwdata[15:0];
                REG_STEP_Y:      step_y_reg      <= pwdata[15:0];
                REG_RATIO_YX:    ratio_yx_reg    <= pwdata;
                REG_RATIO_XY:    ratio_xy_reg    <= pwdata;
                REG_FORCING:     forcing_reg     <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_GRID_WIDTH:  prdata = {21'd0, grid_width_reg};
            REG_GRID_HEIGHT: prdata = {19'd0, grid_height_reg};
            REG_STEP_X:      prdata = {16'd0, step_x_reg};
            REG_STEP_Y:      prdata = {16'd0, step_y_reg};
            REG_RATIO_YX:    prdata = ratio_yx_reg;
            REG_RATIO_XY:    prdata = ratio_xy_reg;
            REG_FORCING:     prdata = forcing_reg;
            default:         prdata = '0;
        endcase
    end

    psr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    psr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_tdata        (s_tdata),
        .grid_width     (grid_width_reg),
        .grid_height    (grid_height_reg),
        .phase_step_x   (step_x_reg),
        .phase_step_y   (step_y_reg),
        .ratio_y_over_x (ratio_yx_reg),
        .ratio_x_over_y (ratio_xy_reg),
        .forcing_scale  (forcing_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast)
    );

endmodule

>>> design/psr_ctrl.sv
// Sequencing state machine for the stencil residual core.
module psr_ctrl
    import psr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  psr_status_t status,
    output psr_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RDC  = 4'd1;
    localparam logic [3:0] ST_RDE  = 4'd2;
    localparam logic [3:0] ST_PREP = 4'd3;
    localparam logic [3:0] ST_M1   = 4'd4;
    localparam logic [3:0] ST_M2   = 4'd5;
    localparam logic [3:0] ST_M3   = 4'd6;
    localparam logic [3:0] ST_M4   = 4'd7;
    localparam logic [3:0] ST_M5   = 4'd8;
    localparam logic [3:0] ST_M6   = 4'd9;
    localparam logic [3:0] ST_M7   = 4'd10;
    localparam logic [3:0] ST_OUT1 = 4'd11;
    localparam logic [3:0] ST_OUT2 = 4'd12;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_XL;
        cmd.acc_op = ACC_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RDC;
                end
            end
            ST_RDC: begin
                cmd.rd_ctr = 1'b1;
                state_next = ST_RDE;
            end
            ST_RDE: begin
                cmd.rd_east = 1'b1;
                state_next  = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_M1;
            end
            ST_M1: begin
                cmd.mul_op = MUL_XL;
                state_next = ST_M2;
            end
            ST_M2: begin
                cmd.mul_op = MUL_XH;
                cmd.acc_op = ACC_LOAD;
                state_next = ST_M3;
            end
            ST_M3: begin
                cmd.mul_op = MUL_YL;
                cmd.acc_op = ACC_HI;
                state_next = ST_M4;
            end
            ST_M4: begin
                cmd.mul_op = MUL_YH;
                cmd.acc_op = ACC_LOAD;
                state_next = ST_M5;
            end
            ST_M5: begin
                cmd.mul_op = MUL_CC;
                cmd.acc_op = ACC_HI;
                state_next = ST_M6;
            end
            ST_M6: begin
                cmd.mul_op = MUL_F;
                state_next = ST_M7;
            end
            ST_M7: begin
                cmd.acc_op = ACC_SUB;
                if (status.has_prev) begin
                    state_next = ST_OUT1;
                end else if (status.last_row) begin
                    state_next = ST_OUT2;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT1: begin
                if (status.out_free) begin
                    cmd.load_prev_res = 1'b1;
                    state_next = status.last_row ? ST_OUT2 : ST_IDLE;
                end
            end
            ST_OUT2: begin
                if (status.out_free) begin
                    cmd.load_row_res = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> design/psr_datapath.sv
// Line stores, counters, shared multiplier and output register of the residual core.
module psr_datapath
    import psr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  psr_cmd_t    cmd,
    output psr_status_t status,
    input  logic [31:0] s_tdata,
    input  logic [10:0] grid_width,
    input  logic [12:0] grid_height,
    input  logic [15:0] phase_step_x,
    input  logic [15:0] phase_step_y,
    input  logic [31:0] ratio_y_over_x,
    input  logic [31:0] ratio_x_over_y,
    input  logic [31:0] forcing_scale,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast
);

    logic [31:0] prev_row_mem  [MAX_WIDTH];
    logic [31:0] older_row_mem [MAX_WIDTH];

    // Counters and phase accumulators.
    logic [ADDR_W-1:0] col_cnt_reg;
    logic [11:0]       row_cnt_reg;
    logic [15:0]       phase_x_reg;
    logic [15:0]       phase_y_reg;
    logic signed [31:0] west_reg;

    // Per-item registers.
    logic signed [31:0] v_reg;
    logic [ADDR_W-1:0]  c_reg;
    logic [11:0]        r_reg;
    logic [15:0]        px_reg;
    logic [15:0]        py_reg;
    logic [15:0]        pyc_reg;
    logic               edge_col_reg;
    logic               edge_row_reg;
    logic               last_row_reg;
    logic               last_col_reg;
    logic               has_prev_reg;

    logic signed [31:0] prev_rd_reg;
    logic signed [31:0] older_rd_reg;
    logic signed [31:0] ctr_reg;
    logic signed [34:0] ax_reg;
    logic signed [34:0] ay_reg;
    logic signed [25:0] cosx_reg;
    logic signed [25:0] cosy_reg;
    logic signed [25:0] cosyc_reg;
    logic signed [59:0] prod_reg;
    logic signed [59:0] part_reg;
    logic signed [47:0] sum_reg;

    logic               out_valid_reg;
    logic [55:0]        out_data_reg;
    logic               out_last_reg;

    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic        last_col;
    logic        last_row;
    logic [ADDR_W-1:0] rd_addr;

    logic signed [26:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [67:0] combined;

    logic signed [47:0] prev_diff;
    logic signed [47:0] row_diff;
    logic signed [31:0] prev_res;
    logic signed [31:0] row_res;

    always_comb begin
        if (grid_width < 11'd3) begin
            w_eff = 11'd3;
        end else if (grid_width > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = grid_width;
        end
        if (grid_height < 13'd3) begin
            h_eff = 13'd3;
        end else if (grid_height > 13'(MAX_HEIGHT)) begin
            h_eff = 13'(MAX_HEIGHT);
        end else begin
            h_eff = grid_height;
        end
    end

    assign last_col = 11'(col_cnt_reg) >= (w_eff - 11'd1);
    assign last_row = 13'(row_cnt_reg) >= (h_eff - 13'd1);

    assign status.out_free = !out_valid_reg || m_tready;
    assign status.has_prev = has_prev_reg;
    assign status.last_row = last_row_reg;

    // Counter update and item capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            phase_x_reg <= '0;
            phase_y_reg <= '0;
        end else if (cmd.capture) begin
            if (last_col) begin
                col_cnt_reg <= '0;
                phase_x_reg <= '0;
                if (last_row) begin
                    row_cnt_reg <= '0;
                    phase_y_reg <= '0;
                end else begin
                    row_cnt_reg <= row_cnt_reg + 12'd1;
                    phase_y_reg <= phase_y_reg + phase_step_y;
                end
            end else begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
                phase_x_reg <= phase_x_reg + phase_step_x;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            v_reg        <= $signed(s_tdata);
            c_reg        <= col_cnt_reg;
            r_reg        <= row_cnt_reg;
            px_reg       <= phase_x_reg;
            py_reg       <= phase_y_reg - phase_step_y;
            pyc_reg      <= phase_y_reg;
            last_col_reg <= last_col;
            last_row_reg <= last_row;
            has_prev_reg <= (row_cnt_reg != 12'd0);
            edge_col_reg <= (col_cnt_reg == '0) || last_col;
            edge_row_reg <= (row_cnt_reg == 12'd1) || (13'(row_cnt_reg) >= h_eff);
        end
    end

    // Line stores: read center, then east; write back during prep.
    assign rd_addr = cmd.rd_east ? (c_reg + 1'b1) : c_reg;

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            prev_row_mem[c_reg] <= v_reg;
        end
        if (cmd.rd_ctr || cmd.rd_east) begin
            prev_rd_reg <= prev_row_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            older_row_mem[c_reg] <= ctr_reg;
        end
        if (cmd.rd_ctr) begin
            older_rd_reg <= older_row_mem[c_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            west_reg <= '0;
        end else if (cmd.prep) begin
            west_reg <= ctr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_east) begin
            ctr_reg <= prev_rd_reg;
        end
        if (cmd.prep) begin
            ax_reg    <= (35'(ctr_reg) <<< 1) - 35'(prev_rd_reg) - 35'(west_reg);
            ay_reg    <= (35'(ctr_reg) <<< 1) - 35'(older_rd_reg) - 35'(v_reg);
            cosx_reg  <= cos_q24(px_reg);
            cosy_reg  <= cos_q24(py_reg);
            cosyc_reg <= cos_q24(pyc_reg);
        end
    end

    // Shared multiplier: the 35-bit differences go through as low and high halves.
    always_comb begin
        case (cmd.mul_op)
            MUL_XL: begin
                mul_a = $signed({10'd0, ax_reg[16:0]});
                mul_b = $signed({1'b0, ratio_y_over_x});
            end
            MUL_XH: begin
                mul_a = 27'($signed(ax_reg[34:17]));
                mul_b = $signed({1'b0, ratio_y_over_x});
            end
            MUL_YL: begin
                mul_a = $signed({10'd0, ay_reg[16:0]});
                mul_b = $signed({1'b0, ratio_x_over_y});
            end
            MUL_YH: begin
                mul_a = 27'($signed(ay_reg[34:17]));
                mul_b = $signed({1'b0, ratio_x_over_y});
            end
            MUL_CC: begin
                mul_a = 27'(cosx_reg);
                mul_b = 33'(cosy_reg);
            end
            MUL_F: begin
                mul_a = prod_reg[50:24];
                mul_b = $signed({1'b0, forcing_scale});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign combined = 68'(part_reg) + (68'(prod_reg) <<< 17);

    always_ff @(posedge aclk) begin
        prod_reg <= 60'(mul_a * mul_b);
        if (cmd.prep) begin
            sum_reg <= '0;
        end else begin
            case (cmd.acc_op)
                ACC_LOAD: part_reg <= prod_reg;
                ACC_HI:   sum_reg  <= sum_reg + 48'($signed(combined[67:24]));
                ACC_SUB:  sum_reg  <= sum_reg - 48'($signed(prod_reg[59:24]));
                default:  ;
            endcase
        end
    end

    // Result selection.
    assign prev_diff = 48'(ctr_reg) - 48'(edge_col_reg ? cosy_reg : cosx_reg);
    assign row_diff  = 48'(v_reg) - 48'(edge_col_reg ? cosyc_reg : cosx_reg);

    always_comb begin
        if (edge_col_reg || edge_row_reg) begin
            prev_res = sat32(prev_diff);
        end else begin
            prev_res = sat32(sum_reg);
        end
        row_res = sat32(row_diff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_prev_res || cmd.load_row_res) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_prev_res) begin
            out_data_reg <= {2'b00, 10'(c_reg), r_reg - 12'd1, prev_res};
            out_last_reg <= 1'b0;
        end else if (cmd.load_row_res) begin
            out_data_reg <= {2'b00, 10'(c_reg), r_reg, row_res};
            out_last_reg <= last_col_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> design/psr_checker.sv
// Port-level checks for the residual core, bound to the top level.
module psr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    // A result beat stays offered until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // The core works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in progress");

    // Reset leaves the core empty and ready for input.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("core not empty after reset");

endmodule

bind poisson_stencil_residual_core psr_checker u_psr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
